[rtl/core/kvs_pkg.sv]
// kvs_pkg: shared types and codes for the key/value store
// holds the request and token structs passed between the top level and the cells
// no dependencies
package kvs_pkg;

  // request action codes
  localparam logic ACT_PUT = 1'b0;
  localparam logic ACT_GET = 1'b1;

  // request held for the duration of one lookup walk
  typedef struct packed {
    logic               action;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  // lookup token handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic               hit;
    logic               free_seen;
    logic signed [31:0] read_value;
  } tok_t;

endpackage

[rtl/core/key_value_store.sv]
// key_value_store: bounded associative table of signed 32-bit keys and values
// top level, builds a row of kvs_cell entries and the request/result control
// depends on kvs_pkg and kvs_cell
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------
//   request  | in_valid / in_ready   | action, key, value
//   result   | out_valid / out_ready | read_value, hit, entry_count, full_drop
//
// one request in flight at a time: a launch step, the lookup token walking the
// cell row cell by cell, and the commit at the end of the row
// rst is synchronous, clears valid bits, count, token stages and handshake state
// a finished result sits in the output register; the next request is taken
// while it waits, and the row only stalls if a new result is due before the
// old one is taken
module key_value_store
  import kvs_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic signed [31:0] key,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] read_value,
  output logic               hit,
  output logic [4:0]         entry_count,
  output logic               full_drop
);

  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t          state;
  state_t          state_next;
  req_t            req;
  logic            start;
  logic            en;
  logic            in_xfer;
  logic            finish;
  logic            ins;
  logic            drop;
  logic [CW-1:0]   held_count;
  logic [CW-1:0]   held_count_next;
  logic [CW+4:0]   count_wide;
  tok_t            chain [ENTRIES+1];
  tok_t            last_tok;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // whole row freezes only when a result is due and the output register is full
  assign last_tok = chain[ENTRIES];
  assign en       = !(last_tok.valid && out_valid && !out_ready);
  assign finish   = last_tok.valid && en;

  // launch token enters cell 0
  always_comb begin
    chain[0]            = '0;
    chain[0].valid      = start;
  end

  // cell row, each entry hands the token to its neighbor every cycle unless the row is frozen
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kvs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .req       (req),
      .tok_in    (chain[i]),
      .tok_out   (chain[i+1]),
      .commit    (finish),
      .final_hit (last_tok.hit)
    );
  end

  // decision at the end of the walk
  assign ins  = (req.action == ACT_PUT) && !last_tok.hit && last_tok.free_seen;
  assign drop = (req.action == ACT_PUT) && !last_tok.hit && !last_tok.free_seen;
  assign held_count_next = held_count + CW'(ins);

  // request register, loaded on transfer, held through the walk
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req.action <= action;
      req.key    <= key;
      req.value  <= value;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_xfer) state_next = ST_WALK;
      ST_WALK: if (finish)  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      start      <= 1'b0;
      held_count <= '0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        start <= 1'b1;
      end else if (en) begin
        start <= 1'b0;
      end
      if (finish) begin
        held_count <= held_count_next;
      end
    end
  end

  // count field is the low five bits of the entry count
  assign count_wide = {5'd0, held_count_next};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      read_value  <= last_tok.read_value;
      hit         <= last_tok.hit;
      entry_count <= count_wide[4:0];
      full_drop   <= drop;
    end
  end

  // a token reaches the end of the row only during a walk
  a_tok_in_walk: assert property (@(posedge clk) disable iff (rst)
    last_tok.valid |-> (state == ST_WALK))
    else $error("token at end of row outside a walk");

  // the count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(ENTRIES))
    else $error("entry count above capacity");

  // a dropped put never also reports a hit
  a_drop_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(full_drop && hit))
    else $error("drop and hit both set");

  // a request transfer launches a token next cycle
  a_launch: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> start)
    else $error("request transfer did not launch a token");

endmodule

[rtl/core/kvs_cell.sv]
// kvs_cell: one table entry of the key/value store cell row
// compares the passing token against its entry and commits writes at walk end
// depends on kvs_pkg
module kvs_cell
  import kvs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  req_t req,
  input  tok_t tok_in,
  output tok_t tok_out,
  input  logic commit,
  input  logic final_hit
);

  logic               entry_valid;
  logic signed [31:0] entry_key;
  logic signed [31:0] entry_value;
  logic               is_match;
  logic               is_free;
  logic               match_now;
  logic               free_now;
  tok_t               tok_next;

  assign match_now = entry_valid && (entry_key == req.key);
  assign free_now  = !entry_valid && !tok_in.free_seen;

  always_comb begin
    tok_next            = tok_in;
    tok_next.hit        = tok_in.hit | match_now;
    tok_next.free_seen  = tok_in.free_seen | !entry_valid;
    if (match_now && !tok_in.hit && (req.action == ACT_GET)) begin
      tok_next.read_value = entry_value;
    end
  end

  // token stage and match flags
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out  <= '0;
      is_match <= 1'b0;
      is_free  <= 1'b0;
    end else if (en) begin
      tok_out <= tok_next;
      if (tok_in.valid) begin
        is_match <= match_now;
        is_free  <= free_now;
      end
    end
  end

  // entry valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (commit && (req.action == ACT_PUT) && !final_hit && is_free) begin
      entry_valid <= 1'b1;
    end
  end

  // entry payload, no reset
  always_ff @(posedge clk) begin
    if (commit && (req.action == ACT_PUT)) begin
      if (is_match) begin
        entry_value <= req.value;
      end else if (!final_hit && is_free) begin
        entry_key   <= req.key;
        entry_value <= req.value;
      end
    end
  end

endmodule
